// ===== rtl/core/lcgrr_pkg.sv =====
// Shared types and constants of the range-limited LCG draw unit.
package lcgrr_pkg;

	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_ADD = 32'd12345;
	localparam int TAKE_SHIFT = 16;
	localparam int VAL_W = 32 - TAKE_SHIFT;
	localparam int CNT_W = $clog2(VAL_W);
	localparam logic [31:0] SEED_RESET = 32'd1;

	localparam logic [1:0] CMD_RESEED  = 2'd0;
	localparam logic [1:0] CMD_BELOW   = 2'd1;
	localparam logic [1:0] CMD_BETWEEN = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// One draw job handed from the front end to the remainder unit.
	typedef struct packed {
		logic             direct;   // result is offset alone, no remainder
		logic [VAL_W-1:0] value;
		logic [31:0]      divisor;
		logic [31:0]      offset;
	} job_t;

endpackage

// ===== rtl/core/lcg_random_in_range_core.sv =====
// Top level of the range-limited LCG draw unit.
// A reseed word is taken and gives no output. A draw word passes the front-end steps
// (accept, 32x32 multiply, add, hand-off) and then the back end: a load step, sixteen
// steps of the restoring remainder unit (one bit of the 16-bit drawn value per step)
// and a step into the output register. The remainder unit takes no new job until it
// has written its result, so it sets the sustained rate; a two-entry job queue lets
// the front end run ahead. Draws that need no remainder (nonpositive limit, empty
// interval) skip the remainder steps in the back end, and an empty interval also skips
// the multiply and add in the front end.
module lcg_random_in_range_core import lcgrr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [1:0]   s_axis_tuser,  // command
	input  logic [127:0] s_axis_tdata,  // new_seed, range_limit, low_bound, high_bound
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [31:0]  m_axis_tdata   // drawn_value
);

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	job_t fq_job, qb_job;

	lcgrr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	lcgrr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_job    (qb_job)
	);

	lcgrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== rtl/core/lcgrr_front.sv =====
// Front end: accepts words, keeps the generator state and issues draw jobs.
module lcgrr_front import lcgrr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   in_cmd,
	input  logic [127:0] in_data,
	output logic         job_valid,
	input  logic         job_ready,
	output job_t         job
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_ADD  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	logic [1:0]  state_q;
	logic [31:0] seed_q;
	logic [31:0] prod_q;
	job_t        job_q;
	logic [31:0] new_seed, range_limit, low_bound, high_bound;
	logic [31:0] next_seed;
	logic        limit_pos, interval_ok;

	assign new_seed    = in_data[31:0];
	assign range_limit = in_data[63:32];
	assign low_bound   = in_data[95:64];
	assign high_bound  = in_data[127:96];

	assign limit_pos   = (range_limit != 32'd0) && !range_limit[31];
	assign interval_ok = $signed(low_bound) < $signed(high_bound);
	assign next_seed   = prod_q + LCG_ADD;

	assign in_ready  = (state_q == F_IDLE);
	assign job_valid = (state_q == F_PUSH);
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			seed_q  <= SEED_RESET;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						unique case (in_cmd)
							CMD_RESEED: begin
								if (new_seed != 32'd0) begin
									seed_q <= new_seed;
								end
							end
							CMD_BELOW: state_q <= F_MUL;
							CMD_BETWEEN: begin
								state_q <= interval_ok ? F_MUL : F_PUSH;
							end
							CMD_UNUSED: state_q <= F_IDLE;
						endcase
					end
				end
				F_MUL: state_q <= F_ADD;
				F_ADD: begin
					seed_q  <= next_seed;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			job_q.value <= '0;
			if (in_cmd == CMD_BELOW) begin
				job_q.direct  <= !limit_pos;
				job_q.divisor <= range_limit;
				job_q.offset  <= 32'd0;
			end else begin
				job_q.direct  <= !interval_ok;
				job_q.divisor <= high_bound - low_bound;
				job_q.offset  <= low_bound;
			end
		end
		if (state_q == F_MUL) begin
			prod_q <= 32'(seed_q * LCG_MUL);
		end
		if (state_q == F_ADD) begin
			job_q.value <= next_seed[31:TAKE_SHIFT];
		end
	end

endmodule

// ===== rtl/core/lcgrr_queue.sv =====
// Short job queue between the front end and the remainder unit.
module lcgrr_queue import lcgrr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/core/lcgrr_back.sv =====
// Back end: restoring remainder unit and the output word register.
module lcgrr_back import lcgrr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_data
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV  = 2'd1;
	localparam logic [1:0] B_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      rem_q, div_q, off_q;
	logic [VAL_W-1:0] val_q;
	logic             out_valid_q;
	logic [31:0]      out_data_q;
	logic [32:0]      trial;
	logic             fits;
	logic             out_free;

	// One quotient bit per cycle; the remainder always stays below the divisor.
	assign trial    = {rem_q, val_q[VAL_W-1]};
	assign fits     = trial >= {1'b0, div_q};
	assign out_free = !out_valid_q || out_ready;

	assign job_ready = (state_q == B_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						cnt_q   <= '0;
						state_q <= job.direct ? B_DONE : B_DIV;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(VAL_W - 1)) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && job_valid) begin
			rem_q <= 32'd0;
			val_q <= job.value;
			div_q <= job.divisor;
			off_q <= job.offset;
		end
		if (state_q == B_DIV) begin
			rem_q <= fits ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			val_q <= {val_q[VAL_W-2:0], 1'b0};
		end
		if (state_q == B_DONE && out_free) begin
			out_data_q <= off_q + rem_q;
		end
	end

endmodule

// ===== rtl/core/lcgrr_checker.sv =====
// Port-level checks of the draw unit, bound to the top level.
module lcgrr_checker import lcgrr_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [1:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [31:0]  m_axis_tdata
);

	logic in_take;
	assign in_take = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// A word that gives no result is finished in its accept cycle.
	a_no_result_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && (s_axis_tuser == CMD_RESEED || s_axis_tuser == CMD_UNUSED)
		|=> s_axis_tready)
		else $error("front end busy after reseed or unused word");

	// A draw below the limit always advances the state, which takes the front end.
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && s_axis_tuser == CMD_BELOW |=> !s_axis_tready)
		else $error("front end ready during state advance");

endmodule

bind lcg_random_in_range_core lcgrr_checker u_lcgrr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
